// File: sv/f12te_pkg.sv
// ----------------------------------------------------------------------------
// f12te_pkg
// shared types and constants of the fat12 allocation-table engine
// ----------------------------------------------------------------------------
package f12te_pkg;

    // table geometry, table size must be a power of two
    localparam int TABLE_BYTES = 1024;
    localparam int BYTE_AW     = $clog2(TABLE_BYTES);
    localparam int BANK_DEPTH  = TABLE_BYTES / 2;
    localparam int BANK_AW     = $clog2(BANK_DEPTH);

    // chain walk bound
    localparam int CHAIN_LIMIT = 4096;
    localparam int CNT_W       = $clog2(CHAIN_LIMIT);

    // field widths
    localparam int OP_W     = 3;
    localparam int ENTRY_W  = 12;
    localparam int BIDX_W   = 10;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;

    localparam logic [ENTRY_W-1:0] END_MARK            = 12'hFF8;
    localparam logic [ENTRY_W-1:0] FIRST_CLUSTER       = 12'd2;
    localparam logic [ENTRY_W-1:0] CLUSTER_LIMIT_RESET = 12'd4084;

    typedef enum logic [OP_W-1:0] {
        OP_READ  = 3'd0,
        OP_WRITE = 3'd1,
        OP_FREE  = 3'd2,
        OP_CHAIN = 3'd3,
        OP_LOAD  = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_LOOP    = 2'd2
    } status_t;

endpackage

// File: sv/f12te_req_if.sv
// ----------------------------------------------------------------------------
// f12te_req_if
// request channel of the table engine, valid/ready with operation payload
// ----------------------------------------------------------------------------
interface f12te_req_if;

    logic                                valid;
    logic                                ready;
    logic [f12te_pkg::OP_W-1:0]          op;
    logic [f12te_pkg::ENTRY_W-1:0]       cluster;
    logic [f12te_pkg::ENTRY_W-1:0]       new_value;
    logic [f12te_pkg::BIDX_W-1:0]        byte_index;
    logic [f12te_pkg::BYTE_W-1:0]        byte_value;

    modport source (
        output valid, op, cluster, new_value, byte_index, byte_value,
        input  ready
    );

    modport sink (
        input  valid, op, cluster, new_value, byte_index, byte_value,
        output ready
    );

endinterface

// File: sv/f12te_rsp_if.sv
// ----------------------------------------------------------------------------
// f12te_rsp_if
// response channel of the table engine, valid/ready with result payload
// ----------------------------------------------------------------------------
interface f12te_rsp_if;

    logic                                valid;
    logic                                ready;
    logic [f12te_pkg::ENTRY_W-1:0]       entry_value;
    logic [f12te_pkg::ENTRY_W-1:0]       found_cluster;
    logic [f12te_pkg::STATUS_W-1:0]      status;

    modport source (
        output valid, entry_value, found_cluster, status,
        input  ready
    );

    modport sink (
        input  valid, entry_value, found_cluster, status,
        output ready
    );

endinterface

// File: sv/f12te_ram.sv
// ----------------------------------------------------------------------------
// f12te_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module f12te_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/fat12_table_engine.sv
// ----------------------------------------------------------------------------
// fat12_table_engine
// fat12 allocation table kept as packed 12-bit entries in two byte banks
// ----------------------------------------------------------------------------
//
//  channel | direction | payload                                 | handshake
//  --------+-----------+-----------------------------------------+-------------
//  req     | in        | op, cluster, new_value, byte_index,     | valid/ready
//          |           | byte_value                              |
//  rsp     | out       | entry_value, found_cluster, status      | valid/ready
//  cfg     | in        | cfg_wdata (cluster_limit)               | cfg_we only
//
//  read, write, load and undefined ops issue the entry read when the item is
//  accepted (a load writes its byte then) and finish in S_EVAL, where the
//  registered bank output gives the result or the write-back is made
//  free search reads one cluster per step from the first data cluster up to
//  the limit until a free one turns up (none when the limit is below it),
//  chain walk one entry per step (at most CHAIN_LIMIT); one read of both banks per step
//  a new item is taken only while the engine is idle; a finished result waits
//  in place while the output register still holds an item not yet taken
//  reset clears control state only; table bytes hold nothing until loaded,
//  so there is no clearing pass
//
module fat12_table_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    f12te_req_if.sink                     req,
    f12te_rsp_if.source                   rsp,
    input  logic                          cfg_we,
    input  logic [f12te_pkg::ENTRY_W-1:0] cfg_wdata
);

    localparam int EW = f12te_pkg::ENTRY_W;
    localparam int BA = f12te_pkg::BANK_AW;
    localparam int YA = f12te_pkg::BYTE_AW;
    localparam int CW = f12te_pkg::CNT_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EVAL  = 4'b0010,
        S_FREE  = 4'b0100,
        S_CHAIN = 4'b1000
    } state_t;

    // byte offset of an entry, wrapped to the table size
    function automatic logic [YA-1:0] entry_offset(input logic [EW-1:0] c);
        logic [EW:0] sum;
        sum = {1'b0, c} + {2'b00, c[EW-1:1]};
        return sum[YA-1:0];
    endfunction

    // the two bytes of an entry always sit in opposite banks; the even bank
    // holds the upper byte one row on when the offset is odd (wraps to row 0)
    function automatic logic [BA-1:0] even_row(input logic [YA-1:0] off);
        return off[0] ? (off[YA-1:1] + BA'(1)) : off[YA-1:1];
    endfunction

    state_t                           state_reg, state_next;
    f12te_pkg::op_t                   op_reg, op_next;
    logic [EW-1:0]                    cur_reg, cur_next;
    logic [EW-1:0]                    nv_reg, nv_next;
    logic [CW-1:0]                    cnt_reg, cnt_next;
    logic [EW-1:0]                    limit_reg;

    logic                             out_valid_reg;
    logic [EW-1:0]                    out_ev_reg, out_fc_reg;
    logic [f12te_pkg::STATUS_W-1:0]   out_st_reg;

    logic                             accept;
    logic                             can_put;
    logic                             done;
    logic                             finish;
    logic                             wr_en;
    logic                             load_we;
    logic [EW-1:0]                    res_ev, res_fc;
    f12te_pkg::status_t               res_st;

    // bank ports
    logic [YA-1:0]                    rd_off, cur_off;
    logic [YA-1:0]                    load_addr;
    logic                             even_we, odd_we;
    logic [BA-1:0]                    even_waddr, odd_waddr;
    logic [7:0]                       even_wdata, odd_wdata;
    logic [7:0]                       even_rdata, odd_rdata;

    // entry decode of the word read for cur_reg
    logic [15:0]                      word;
    logic [15:0]                      word_new;
    logic [EW-1:0]                    entry;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign can_put   = !out_valid_reg || rsp.ready;
    assign finish    = done && can_put;

    assign cur_off = entry_offset(cur_reg);
    assign rd_off  = entry_offset(cur_next);

    // little-endian word from the two banks
    assign word  = cur_off[0] ? {even_rdata, odd_rdata} : {odd_rdata, even_rdata};
    assign entry = cur_reg[0] ? word[15:4] : word[EW-1:0];

    // odd cluster keeps the low nibble, even cluster keeps the high nibble
    assign word_new = cur_reg[0] ? {nv_reg, word[3:0]} : {word[15:12], nv_reg};

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cur_next   = cur_reg;
        nv_next    = nv_reg;
        cnt_next   = cnt_reg;
        done       = 1'b0;
        wr_en      = 1'b0;
        load_we    = 1'b0;
        res_ev     = '0;
        res_fc     = '0;
        res_st     = f12te_pkg::ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = f12te_pkg::op_t'(req.op);
                    nv_next  = req.new_value;
                    cur_next = req.cluster;
                    cnt_next = '0;
                    case (req.op)
                        f12te_pkg::OP_FREE:
                        begin
                            cur_next   = f12te_pkg::FIRST_CLUSTER;
                            state_next = S_FREE;
                        end
                        f12te_pkg::OP_CHAIN:
                        begin
                            state_next = S_CHAIN;
                        end
                        f12te_pkg::OP_LOAD:
                        begin
                            load_we    = 1'b1;
                            state_next = S_EVAL;
                        end
                        default:
                        begin
                            state_next = S_EVAL;
                        end
                    endcase
                end
            end
            S_EVAL:
            begin
                done = 1'b1;
                if (op_reg == f12te_pkg::OP_READ)
                begin
                    res_ev = entry;
                end
                wr_en = (op_reg == f12te_pkg::OP_WRITE) && can_put;
            end
            S_FREE:
            begin
                // limit below the first data cluster: nothing to search
                if (limit_reg < f12te_pkg::FIRST_CLUSTER)
                begin
                    done   = 1'b1;
                    res_st = f12te_pkg::ST_NO_FREE;
                end
                else if (entry == '0)
                begin
                    done   = 1'b1;
                    res_fc = cur_reg;
                end
                else if (cur_reg == limit_reg)
                begin
                    done   = 1'b1;
                    res_st = f12te_pkg::ST_NO_FREE;
                end
                else
                begin
                    cur_next = cur_reg + EW'(1);
                end
            end
            S_CHAIN:
            begin
                if (entry >= f12te_pkg::END_MARK)
                begin
                    done   = 1'b1;
                    res_fc = cur_reg;
                end
                else if (cnt_reg == CW'(f12te_pkg::CHAIN_LIMIT - 1))
                begin
                    // step budget used up, report where the walk got to
                    done   = 1'b1;
                    res_fc = entry;
                    res_st = f12te_pkg::ST_LOOP;
                end
                else
                begin
                    cur_next = entry;
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            state_next = S_IDLE;
        end
    end

    // ------------------------------------------------------------------
    // byte banks: even offsets and odd offsets
    // ------------------------------------------------------------------
    assign load_addr = YA'(req.byte_index);

    always_comb
    begin
        even_we    = wr_en || (load_we && !load_addr[0]);
        odd_we     = wr_en || (load_we && load_addr[0]);
        even_waddr = load_we ? load_addr[YA-1:1] : even_row(cur_off);
        odd_waddr  = load_we ? load_addr[YA-1:1] : cur_off[YA-1:1];
        even_wdata = load_we ? req.byte_value
                             : (cur_off[0] ? word_new[15:8] : word_new[7:0]);
        odd_wdata  = load_we ? req.byte_value
                             : (cur_off[0] ? word_new[7:0] : word_new[15:8]);
    end

    f12te_ram #(
        .WIDTH (8),
        .DEPTH (f12te_pkg::BANK_DEPTH)
    ) u_even_bank (
        .clk   (clk),
        .we    (even_we),
        .waddr (even_waddr),
        .wdata (even_wdata),
        .raddr (even_row(rd_off)),
        .rdata (even_rdata)
    );

    f12te_ram #(
        .WIDTH (8),
        .DEPTH (f12te_pkg::BANK_DEPTH)
    ) u_odd_bank (
        .clk   (clk),
        .we    (odd_we),
        .waddr (odd_waddr),
        .wdata (odd_wdata),
        .raddr (rd_off[YA-1:1]),
        .rdata (odd_rdata)
    );

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= f12te_pkg::OP_READ;
            cnt_reg       <= '0;
            limit_reg     <= f12te_pkg::CLUSTER_LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        nv_reg  <= nv_next;
        if (finish)
        begin
            out_ev_reg <= res_ev;
            out_fc_reg <= res_fc;
            out_st_reg <= res_st;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.entry_value   = out_ev_reg;
    assign rsp.found_cluster = out_fc_reg;
    assign rsp.status        = out_st_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_bank_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        (even_we || odd_we) |->
            (accept && req.op == f12te_pkg::OP_LOAD) ||
            (state_reg == S_EVAL && op_reg == f12te_pkg::OP_WRITE))
        else $error("bank written outside a load or entry write");

    a_write_both_banks: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (even_we && odd_we && !load_we))
        else $error("entry write did not update both banks");

    a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (state_reg == S_IDLE && out_valid_reg))
        else $error("finished item not handed to the output register");

    a_free_from_two: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FREE |-> cur_reg >= f12te_pkg::FIRST_CLUSTER)
        else $error("free search below the first data cluster");

    a_no_free_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == f12te_pkg::ST_NO_FREE) |->
            (rsp.found_cluster == '0 && rsp.entry_value == '0))
        else $error("failed free search reports a cluster");

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the fat12 allocation-table engine: a local table
// image predicts every response, random traffic runs under changing idling,
// and one test holds the response side off in a long stall
// ----------------------------------------------------------------------------
module testbench;

    localparam int OP_W        = f12te_pkg::OP_W;
    localparam int ENTRY_W     = f12te_pkg::ENTRY_W;
    localparam int BIDX_W      = f12te_pkg::BIDX_W;
    localparam int BYTE_W      = f12te_pkg::BYTE_W;
    localparam int TABLE_BYTES = f12te_pkg::TABLE_BYTES;
    localparam int CHAIN_LIMIT = f12te_pkg::CHAIN_LIMIT;

    // op codes with no defined behaviour, the engine must answer with zeros
    localparam logic [OP_W-1:0]    OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0]    OP_SPARE_LAST  = 3'd7;

    localparam logic [ENTRY_W-1:0] ENTRY_MAX      = 12'hFFF;

    // clusters 2..681 own disjoint 12-bit slots, cluster 682 already wraps
    // into byte 0 and shares a nibble with cluster 0
    localparam int LAST_PLAIN_CLUSTER = (2 * TABLE_BYTES) / 3 - 1;

    // adding this to a cluster number lands on the very same slot
    localparam int ALIAS_STEP = 2 * TABLE_BYTES;

    // longest legal quiet stretch is one full chain walk plus a held response
    localparam int STALL_LIMIT = 50000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [ENTRY_W-1:0] entry_value;
        logic [ENTRY_W-1:0] found_cluster;
        f12te_pkg::status_t status;
    } fat_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [ENTRY_W-1:0]   cfg_wdata;

    f12te_req_if req_ch ();
    f12te_rsp_if rsp_ch ();

    fat12_table_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // local copy of the table and of the search limit
    // ------------------------------------------------------------------------
    logic [BYTE_W-1:0]    fat_image [TABLE_BYTES];
    logic [ENTRY_W-1:0]   limit_model;

    // responses still owed by the engine, oldest first
    fat_result_t          pending_results [$];
    fat_result_t          last_result;

    int                   mismatches;
    int                   items_sent;
    int                   send_idle_pct;
    int                   recv_idle_pct;
    int                   idle_cycles;
    int                   hold_left;
    bit                   hold_request;

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // table image access
    // ------------------------------------------------------------------------

    // byte offset of a cluster slot: cluster + cluster/2, circular
    function automatic int slot_offset(logic [ENTRY_W-1:0] cluster);
        return (int'(cluster) + int'(cluster) / 2) % TABLE_BYTES;
    endfunction

    // little-endian word, odd clusters in the top 12 bits
    function automatic logic [ENTRY_W-1:0] entry_at(logic [ENTRY_W-1:0] cluster);
        int          lo;
        logic [15:0] word;
        lo   = slot_offset(cluster);
        word = {fat_image[(lo + 1) % TABLE_BYTES], fat_image[lo]};
        return cluster[0] ? word[15:4] : word[11:0];
    endfunction

    // read-modify-write so that the neighbour's nibble survives
    function automatic void put_entry(logic [ENTRY_W-1:0] cluster,
                                      logic [ENTRY_W-1:0] value);
        int          lo;
        int          hi;
        logic [15:0] word;
        lo   = slot_offset(cluster);
        hi   = (lo + 1) % TABLE_BYTES;
        word = {fat_image[hi], fat_image[lo]};
        if (cluster[0])
            word[15:4] = value;
        else
            word[11:0] = value;
        fat_image[lo] = word[7:0];
        fat_image[hi] = word[15:8];
    endfunction

    // ------------------------------------------------------------------------
    // prediction of one response, updating the image on writes and loads
    // ------------------------------------------------------------------------
    function automatic fat_result_t fat_predict(logic [OP_W-1:0]    op,
                                                logic [ENTRY_W-1:0] cluster,
                                                logic [ENTRY_W-1:0] new_value,
                                                logic [BIDX_W-1:0]  byte_index,
                                                logic [BYTE_W-1:0]  byte_value);
        fat_result_t        res;
        logic [ENTRY_W-1:0] cur;
        logic [ENTRY_W-1:0] next;
        int                 n;
        res = '0;
        case (op)
            f12te_pkg::OP_READ:
            begin
                res.entry_value = entry_at(cluster);
            end
            f12te_pkg::OP_WRITE:
            begin
                put_entry(cluster, new_value);
            end
            f12te_pkg::OP_FREE:
            begin
                // first zero slot from cluster 2 up to the limit
                res.status = f12te_pkg::ST_NO_FREE;
                for (n = int'(f12te_pkg::FIRST_CLUSTER);
                     n <= int'(limit_model) && res.status == f12te_pkg::ST_NO_FREE;
                     n++)
                begin
                    if (entry_at(ENTRY_W'(n)) == '0)
                    begin
                        res.found_cluster = ENTRY_W'(n);
                        res.status        = f12te_pkg::ST_OK;
                    end
                end
            end
            f12te_pkg::OP_CHAIN:
            begin
                // anything below the end mark, zero too, is a next link
                cur        = cluster;
                res.status = f12te_pkg::ST_LOOP;
                for (n = 0; n < CHAIN_LIMIT && res.status == f12te_pkg::ST_LOOP; n++)
                begin
                    next = entry_at(cur);
                    if (next >= f12te_pkg::END_MARK)
                        res.status = f12te_pkg::ST_OK;
                    else
                        cur = next;
                end
                res.found_cluster = cur;
            end
            f12te_pkg::OP_LOAD:
            begin
                fat_image[int'(byte_index) % TABLE_BYTES] = byte_value;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // offers one item, returns on the edge that accepts it; valid is left high
    // so that back-to-back items need no second assignment in one step
    task automatic issue(input logic [OP_W-1:0]    op,
                         input logic [ENTRY_W-1:0] cluster,
                         input logic [ENTRY_W-1:0] new_value,
                         input logic [BIDX_W-1:0]  byte_index,
                         input logic [BYTE_W-1:0]  byte_value);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.op         <= op;
        req_ch.cluster    <= cluster;
        req_ch.new_value  <= new_value;
        req_ch.byte_index <= byte_index;
        req_ch.byte_value <= byte_value;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        last_result = fat_predict(op, cluster, new_value, byte_index, byte_value);
        pending_results.push_back(last_result);
        items_sent++;
    endtask

    // shorthand for ops that use only the cluster and the new value
    task automatic issue_entry(input logic [OP_W-1:0]    op,
                               input logic [ENTRY_W-1:0] cluster,
                               input logic [ENTRY_W-1:0] new_value);
        issue(op, cluster, new_value, BIDX_W'($urandom), BYTE_W'($urandom));
    endtask

    // stop offering and wait for every owed response
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // the limit register is only touched while the engine is idle
    task automatic set_limit(input logic [ENTRY_W-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        limit_model = value;
    endtask

    function automatic logic [ENTRY_W-1:0] random_end_mark();
        return f12te_pkg::END_MARK +
               ENTRY_W'($urandom_range(0, int'(ENTRY_MAX - f12te_pkg::END_MARK)));
    endfunction

    // ------------------------------------------------------------------------
    // response side: acceptance, checking and the long hold-off
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch on %s: got %0h, expected %0h", what, got, want);
        mismatches++;
    endtask

    task automatic check_response();
        fat_result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("response with nothing pending", 16'h0, 16'h0);
        end
        else
        begin
            want = pending_results.pop_front();
            if (rsp_ch.entry_value !== want.entry_value)
                report_mismatch("entry_value", 16'(rsp_ch.entry_value),
                                16'(want.entry_value));
            if (rsp_ch.found_cluster !== want.found_cluster)
                report_mismatch("found_cluster", 16'(rsp_ch.found_cluster),
                                16'(want.found_cluster));
            if (rsp_ch.status !== want.status)
                report_mismatch("status", 16'(rsp_ch.status), 16'(want.status));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            check_response();
        // a hold-off request starts a stretch of cycles counted here
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles in which no item moves on either channel
    always @(posedge clk)
    begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // loads every table byte so no later access touches undefined contents;
    // plenty of zero bytes keep free slots around for the searches
    task automatic test_table_fill();
        int i;
        for (i = 0; i < TABLE_BYTES; i++)
            issue(f12te_pkg::OP_LOAD, ENTRY_W'($urandom), ENTRY_W'($urandom),
                  BIDX_W'(i), ($urandom_range(99) < 40) ? '0 : BYTE_W'($urandom));
    endtask

    // slot packing, nibble sharing, aliasing of high clusters and the wrap
    // of the last slot into byte 0
    task automatic test_entry_access();
        issue_entry(f12te_pkg::OP_WRITE, 12'd0, ENTRY_MAX);
        issue_entry(f12te_pkg::OP_WRITE, 12'd1, 12'd0);
        issue_entry(f12te_pkg::OP_READ, 12'd0, 12'd0);
        issue_entry(f12te_pkg::OP_READ, 12'd1, 12'd0);
        issue_entry(f12te_pkg::OP_WRITE, ENTRY_MAX, 12'hABC);
        issue_entry(f12te_pkg::OP_READ, ENTRY_MAX, 12'd0);
        issue_entry(f12te_pkg::OP_READ, ENTRY_W'(int'(ENTRY_MAX) - ALIAS_STEP), 12'd0);
        issue_entry(f12te_pkg::OP_WRITE, ENTRY_W'(LAST_PLAIN_CLUSTER + 1), 12'h5A5);
        issue_entry(f12te_pkg::OP_READ, ENTRY_W'(LAST_PLAIN_CLUSTER + 1), 12'd0);
        issue_entry(f12te_pkg::OP_READ, 12'd0, 12'd0);
        issue(f12te_pkg::OP_LOAD, 12'd0, 12'd0, BIDX_W'(TABLE_BYTES - 1), 8'hFF);
        issue(f12te_pkg::OP_LOAD, ENTRY_MAX, ENTRY_MAX, '0, 8'h00);
        issue_entry(f12te_pkg::OP_READ, ENTRY_W'(LAST_PLAIN_CLUSTER + 1), 12'd0);
        issue_entry(f12te_pkg::OP_READ, 12'd0, 12'd0);
    endtask

    // free search: found at the first slot, nothing when the limit is the first data cluster,
    // and a search under the highest limit
    task automatic test_free_search();
        issue_entry(f12te_pkg::OP_WRITE, f12te_pkg::FIRST_CLUSTER, 12'd0);
        issue_entry(f12te_pkg::OP_FREE, 12'd0, 12'd0);
        issue_entry(f12te_pkg::OP_WRITE, f12te_pkg::FIRST_CLUSTER, f12te_pkg::END_MARK);
        set_limit(f12te_pkg::FIRST_CLUSTER);
        issue_entry(f12te_pkg::OP_FREE, 12'd0, 12'd0);
        set_limit(ENTRY_MAX);
        issue_entry(f12te_pkg::OP_FREE, ENTRY_MAX, ENTRY_MAX);
        set_limit(f12te_pkg::CLUSTER_LIMIT_RESET);
    endtask

    // chain walk: a short chain, a zero link, the link just below the end
    // mark, a start that is already the end, and a loop that uses up the limit
    task automatic test_chain_walk();
        issue_entry(f12te_pkg::OP_WRITE, 12'd0, ENTRY_MAX);
        issue_entry(f12te_pkg::OP_WRITE, 12'd10, 12'd11);
        issue_entry(f12te_pkg::OP_WRITE, 12'd11, f12te_pkg::END_MARK);
        issue_entry(f12te_pkg::OP_CHAIN, 12'd10, 12'd0);
        issue_entry(f12te_pkg::OP_WRITE, 12'd12, 12'd0);
        issue_entry(f12te_pkg::OP_CHAIN, 12'd12, 12'd0);
        issue_entry(f12te_pkg::OP_WRITE, f12te_pkg::END_MARK - 12'd1, ENTRY_MAX);
        issue_entry(f12te_pkg::OP_WRITE, 12'd20, f12te_pkg::END_MARK - 12'd1);
        issue_entry(f12te_pkg::OP_CHAIN, 12'd20, 12'd0);
        issue_entry(f12te_pkg::OP_CHAIN, 12'd11, 12'd0);
        issue_entry(f12te_pkg::OP_WRITE, 12'd30, 12'd30);
        issue_entry(f12te_pkg::OP_CHAIN, 12'd30, 12'd0);
    endtask

    // undefined ops must leave the table alone and answer with zeros
    task automatic test_spare_ops();
        logic [OP_W-1:0] op;
        for (op = OP_SPARE_FIRST; op != OP_SPARE_FIRST - 1; op++)
        begin
            issue(op, ENTRY_W'($urandom), ENTRY_W'($urandom), BIDX_W'($urandom),
                  BYTE_W'($urandom));
            if (op == OP_SPARE_LAST)
                break;
        end
        issue_entry(f12te_pkg::OP_READ, 12'd10, 12'd0);
    endtask

    // response side held off while requests keep coming, engine must stall
    task automatic test_backpressure();
        int i;
        hold_request = 1'b1;
        for (i = 0; i < 10; i++)
            issue_entry(f12te_pkg::OP_READ, ENTRY_W'($urandom), 12'd0);
    endtask

    // builds a chain over distinct plain clusters and walks it from the head
    task automatic walk_fresh_chain();
        int                 hops [6];
        int                 len;
        int                 i;
        int                 j;
        bit                 clash;
        logic [ENTRY_W-1:0] link;
        len = $urandom_range(1, 6);
        for (i = 0; i < len; i++)
        begin
            do
            begin
                hops[i] = $urandom_range(int'(f12te_pkg::FIRST_CLUSTER),
                                         LAST_PLAIN_CLUSTER);
                clash   = 1'b0;
                for (j = 0; j < i; j++)
                    if (hops[j] == hops[i])
                        clash = 1'b1;
            end
            while (clash);
        end
        for (i = 0; i < len; i++)
        begin
            if (i == len - 1)
                link = random_end_mark();
            else
                link = ENTRY_W'(hops[i + 1] + ($urandom_range(1) ? ALIAS_STEP : 0));
            issue_entry(f12te_pkg::OP_WRITE, ENTRY_W'(hops[i]), link);
        end
        issue_entry(f12te_pkg::OP_CHAIN,
                    ENTRY_W'(hops[0] + ($urandom_range(1) ? ALIAS_STEP : 0)), 12'd0);
    endtask

    // mostly well-formed traffic: allocate-and-claim, chain build-and-walk,
    // plus plain accesses, loads, stray walks and undefined ops
    task automatic test_random(input int count, input int send_pct, input int recv_pct);
        int                 first;
        int                 pick;
        logic [ENTRY_W-1:0] value;
        logic [ENTRY_W-1:0] claimed;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        first         = items_sent;
        while (items_sent - first < count)
        begin
            pick = $urandom_range(99);
            if (pick < 28)
            begin
                issue_entry(f12te_pkg::OP_READ, ENTRY_W'($urandom), ENTRY_W'($urandom));
            end
            else if (pick < 48)
            begin
                value = ($urandom_range(99) < 25) ? '0 :
                        ($urandom_range(99) < 20) ? random_end_mark() :
                        ENTRY_W'($urandom);
                issue_entry(f12te_pkg::OP_WRITE, ENTRY_W'($urandom), value);
            end
            else if (pick < 62)
            begin
                issue(f12te_pkg::OP_LOAD, ENTRY_W'($urandom), ENTRY_W'($urandom),
                      BIDX_W'($urandom),
                      ($urandom_range(99) < 30) ? '0 : BYTE_W'($urandom));
            end
            else if (pick < 72)
            begin
                issue_entry(f12te_pkg::OP_FREE, ENTRY_W'($urandom), ENTRY_W'($urandom));
                if (last_result.status == f12te_pkg::ST_OK)
                begin
                    claimed = last_result.found_cluster;
                    issue_entry(f12te_pkg::OP_WRITE, claimed, random_end_mark());
                    issue_entry(f12te_pkg::OP_READ, claimed, 12'd0);
                end
            end
            else if (pick < 90)
            begin
                walk_fresh_chain();
            end
            else if (pick < 94)
            begin
                issue_entry(f12te_pkg::OP_CHAIN, ENTRY_W'($urandom), ENTRY_W'($urandom));
            end
            else
            begin
                issue(OP_W'($urandom_range(int'(OP_SPARE_FIRST), int'(OP_SPARE_LAST))),
                      ENTRY_W'($urandom), ENTRY_W'($urandom), BIDX_W'($urandom),
                      BYTE_W'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        req_ch.valid      = 1'b0;
        req_ch.op         = '0;
        req_ch.cluster    = '0;
        req_ch.new_value  = '0;
        req_ch.byte_index = '0;
        req_ch.byte_value = '0;
        rsp_ch.ready      = 1'b0;
        limit_model       = f12te_pkg::CLUSTER_LIMIT_RESET;
        mismatches        = 0;
        items_sent        = 0;
        idle_cycles       = 0;
        hold_left         = 0;
        hold_request      = 1'b0;
        send_idle_pct     = 31;
        recv_idle_pct     = 56;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_fill();
        test_entry_access();
        test_free_search();
        test_chain_walk();
        test_spare_ops();
        test_backpressure();

        set_limit(ENTRY_MAX);
        test_random(190, 31, 56);
        set_limit(ENTRY_W'($urandom_range(int'(f12te_pkg::FIRST_CLUSTER),
                                          LAST_PLAIN_CLUSTER)));
        test_random(190, 56, 31);
        set_limit(ENTRY_W'($urandom_range(int'(f12te_pkg::FIRST_CLUSTER),
                                          int'(ENTRY_MAX))));
        test_random(190, 0, 0);

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: fat12_table_engine.f
sv/f12te_pkg.sv
sv/f12te_req_if.sv
sv/f12te_rsp_if.sv
sv/f12te_ram.sv
sv/fat12_table_engine.sv
tb/sv/testbench.sv
